FILE: rtl/streaming_pattern_matcher_defines.svh
// Assertion macros used by the checker file of the pattern matcher.
`ifndef STREAMING_PATTERN_MATCHER_DEFINES_SVH
`define STREAMING_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define SPM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pattern matcher assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SPM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pattern matcher assertion failed");

`endif

FILE: rtl/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

   localparam int MAX_PATTERN   = 8;
   localparam int POSITION_BITS = 32;

   // The pattern registers hold eight bytes, so the usable length is capped there too.
   localparam int PATTERN_BYTES = 8;
   localparam int LEN_LIMIT     = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;

   localparam int BYTE_W     = 8;
   localparam int PATTERN_W  = PATTERN_BYTES * BYTE_W;
   localparam int LEN_W      = 4;
   localparam int WINDOW_W   = 32;
   localparam int START_W    = 32;
   localparam int TOTAL_W    = 32;
   localparam int POS_W      = POSITION_BITS;
   localparam int FILL_W     = $clog2(MAX_PATTERN + 1);
   localparam int HIST_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_MAIN   = 3'd0,
      CSR_PATTERN_ALT    = 3'd1,
      CSR_PATTERN_LENGTH = 3'd2,
      CSR_WINDOW_START   = 3'd3,
      CSR_WINDOW_END     = 3'd4
   } spm_csr_index_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern_main;
      logic [PATTERN_W-1:0] pattern_alt;
      logic [LEN_W-1:0]     pattern_length;
      logic [WINDOW_W-1:0]  window_start;
      logic [WINDOW_W-1:0]  window_end;
   } spm_cfg_type;

   // One classified text byte on its way from the front to the back.
   typedef struct packed {
      logic             raw_match;
      logic [POS_W-1:0] start;
      logic             last;
   } spm_entry_type;

   typedef struct packed {
      logic          valid;
      spm_entry_type entry;
   } spm_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } spm_queue_status_type;

endpackage

FILE: rtl/spm_req_if.sv
`timescale 1ns / 1ps

interface spm_req_if
   import spm_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              text_last;

   modport source (output valid, output text_byte, output text_last, input ready);
   modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

FILE: rtl/spm_rsp_if.sv
`timescale 1ns / 1ps

interface spm_rsp_if
   import spm_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               match_found;
   logic [START_W-1:0] match_start;
   logic               stream_done;
   logic [TOTAL_W-1:0] match_total;

   modport source (output valid, output match_found, output match_start,
                   output stream_done, output match_total, input ready);
   modport sink   (input valid, input match_found, input match_start,
                   input stream_done, input match_total, output ready);
endinterface

FILE: rtl/spm_queue.sv
`timescale 1ns / 1ps

module spm_queue
   import spm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  spm_push_type         push,
   input  logic                 pop,
   output spm_entry_type        head,
   output spm_queue_status_type status
);

   spm_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push.valid && !status.full;
      do_pop    = pop && !status.empty;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

FILE: rtl/spm_front.sv
`timescale 1ns / 1ps

module spm_front
   import spm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  spm_cfg_type          cfg,
   input  spm_queue_status_type qstat,
   spm_req_if.sink              req,
   output spm_push_type         push
);

   logic [BYTE_W-1:0] hist_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] hist_in [MAX_PATTERN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic [LEN_W-1:0]      eff_len;
   logic [FILL_W-1:0]     fill_next;
   logic [LEN_W-1:0]      hist_sel;
   logic [BYTE_W-1:0]     text_sel;
   logic [BYTE_W-1:0]     pat_main_byte;
   logic [BYTE_W-1:0]     pat_alt_byte;
   logic                  all_ok;
   logic                  accept;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      eff_len = (cfg.pattern_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
                                                         : cfg.pattern_length;
      fill_next = (fill_ff == FILL_W'(MAX_PATTERN)) ? fill_ff : fill_ff + FILL_W'(1);

      // History as it stands once this byte is shifted in; index 0 is the newest.
      hist_in[0] = req.text_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         hist_in[i] = hist_ff[i-1];
      end

      // Pattern byte k lines up with the byte that arrived eff_len-1-k bytes ago.
      all_ok        = 1'b1;
      hist_sel      = '0;
      text_sel      = '0;
      pat_main_byte = '0;
      pat_alt_byte  = '0;
      for (int k = 0; k < LEN_LIMIT; k++) begin
         if (LEN_W'(k) < eff_len) begin
            hist_sel      = eff_len - LEN_W'(1) - LEN_W'(k);
            text_sel      = hist_in[hist_sel[HIST_IDX_W-1:0]];
            pat_main_byte = cfg.pattern_main[k*BYTE_W +: BYTE_W];
            pat_alt_byte  = cfg.pattern_alt[k*BYTE_W +: BYTE_W];
            if (text_sel != pat_main_byte && text_sel != pat_alt_byte) begin
               all_ok = 1'b0;
            end
         end
      end

      push.valid           = accept;
      push.entry.raw_match = all_ok && (eff_len != '0) &&
                             (LEN_W'(fill_next) >= eff_len);
      push.entry.start     = pos_ff + POS_W'(1) - POS_W'(eff_len);
      push.entry.last      = req.text_last;

      if (req.text_last) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            hist_in[i] = '0;
         end
         fill_in = '0;
         pos_in  = '0;
      end else begin
         fill_in = fill_next;
         pos_in  = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            hist_ff[i] <= '0;
         end
         fill_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         fill_ff <= fill_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

FILE: rtl/spm_back.sv
`timescale 1ns / 1ps

module spm_back
   import spm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  spm_cfg_type          cfg,
   input  spm_entry_type        head,
   input  spm_queue_status_type qstat,
   output logic                 pop,
   spm_rsp_if.source            rsp
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff;
   logic [START_W-1:0] start_ff;
   logic               done_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] counter_ff, counter_in;

   logic               in_window;
   logic               found;
   logic               emit;
   logic [TOTAL_W-1:0] counter_next;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.match_found = found_ff;
   assign rsp.match_start = start_ff;
   assign rsp.stream_done = done_ff;
   assign rsp.match_total = total_ff;

   always_comb begin
      in_window = (cfg.window_start <= cfg.window_end) &&
                  (head.start >= POS_W'(cfg.window_start)) &&
                  (head.start <= POS_W'(cfg.window_end));
      found = head.raw_match && in_window;
      emit  = found || head.last;
      pop   = !qstat.empty && (!rsp_valid_ff || rsp.ready);

      counter_next = (found && counter_ff != '1) ? counter_ff + TOTAL_W'(1) : counter_ff;
      counter_in   = counter_ff;
      if (pop) begin
         counter_in = head.last ? '0 : counter_next;
      end

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         counter_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         counter_ff   <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         found_ff <= found;
         start_ff <= found ? head.start[START_W-1:0] : '0;
         done_ff  <= head.last;
         total_ff <= counter_next;
      end
   end

endmodule

FILE: rtl/streaming_pattern_matcher.sv
`timescale 1ns / 1ps
// Streaming pattern matcher: reports every overlapping occurrence of a pattern of
// up to eight bytes in a byte stream, with a main and an alternate byte allowed
// at each pattern position (load lower and upper case for a case-insensitive search).
// Text bytes arrive on the req channel, one transaction per byte, with text_last
// on the final byte of a text. The rsp channel carries one transaction for each
// byte that completes a match starting inside [window_start, window_end], and one
// for the final byte, which also carries the match total. Other bytes give none.
// Registers are written over the csr port, which is always ready; write them
// only while no text is in flight.
// Throughput is one byte per cycle while results are taken: the front compares the
// shifted history with the pattern and the back applies the window and counter.
// A four-entry queue separates the two halves, and each result is registered in
// the queue and again in the output register before it reaches rsp.
// When the receiver stalls, the pending result holds in the output register, the
// queue fills and req.ready drops once it is full; nothing is lost.
// Reset clears the history, position, counter and queue, and returns the registers
// to their defaults (pattern length one, window covering every position).

module streaming_pattern_matcher
   import spm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   spm_req_if.sink               req,
   spm_rsp_if.source             rsp,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   spm_cfg_type          cfg_ff, cfg_in;
   spm_push_type         push;
   spm_entry_type        head;
   spm_queue_status_type qstat;
   logic                 pop;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (spm_csr_index_type'(csr_index))
            CSR_PATTERN_MAIN:   cfg_in.pattern_main   = csr_data[PATTERN_W-1:0];
            CSR_PATTERN_ALT:    cfg_in.pattern_alt    = csr_data[PATTERN_W-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_data[LEN_W-1:0];
            CSR_WINDOW_START:   cfg_in.window_start   = csr_data[WINDOW_W-1:0];
            CSR_WINDOW_END:     cfg_in.window_end     = csr_data[WINDOW_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_main   <= '0;
         cfg_ff.pattern_alt    <= '0;
         cfg_ff.pattern_length <= LEN_W'(1);
         cfg_ff.window_start   <= '0;
         cfg_ff.window_end     <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front shifts each accepted byte into the history and classifies it.
   spm_front u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .qstat (qstat),
      .req   (req),
      .push  (push)
   );

   spm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (qstat)
   );

   // The back applies the window, keeps the match count and drives rsp.
   spm_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

FILE: rtl/spm_checker.sv
`timescale 1ns / 1ps
`include "streaming_pattern_matcher_defines.svh"

module spm_checker
   import spm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_match_found,
   input logic [START_W-1:0] rsp_match_start,
   input logic               rsp_stream_done,
   input logic [TOTAL_W-1:0] rsp_match_total
);

   // A stalled result keeps its contents.
   `SPM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_match_found) && $stable(rsp_match_start) && $stable(rsp_stream_done) && $stable(rsp_match_total))

   // Reset empties the output register.
   `SPM_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // Every result is either a match or the end of a text.
   `SPM_ASSERT_IMP(a_rsp_reason, clock, reset, rsp_valid, rsp_match_found || rsp_stream_done)

   // Without a match the start field reads zero.
   `SPM_ASSERT_IMP(a_start_zero, clock, reset, rsp_valid && !rsp_match_found, rsp_match_start == '0)

   // A reported match is already included in the total.
   `SPM_ASSERT_IMP(a_total_counts, clock, reset, rsp_valid && rsp_match_found, rsp_match_total != '0)

endmodule

bind streaming_pattern_matcher spm_checker u_spm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_match_found (rsp.match_found),
   .rsp_match_start (rsp.match_start),
   .rsp_stream_done (rsp.stream_done),
   .rsp_match_total (rsp.match_total)
);

FILE: tb/streaming_pattern_matcher_tb.sv
`timescale 1ns / 1ps

module streaming_pattern_matcher_tb;
   import spm_pkg::*;

   // Length of the one long receiver hold-off, in cycles. It is far longer
   // than the internal queue is deep, so the block has to stall its input.
   localparam int LONG_HOLD = 120;
   // Cycles allowed for a byte that yields no result to leave the pipeline.
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_SHOWN = 10;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS = 100;
   localparam longint TIMEOUT_NS = 8_000_000;
   localparam logic [BYTE_W-1:0] EDGE_BYTES [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};

   // One result transaction as the block should produce it.
   typedef struct packed {
      logic               found;
      logic [START_W-1:0] start;
      logic               done;
      logic [TOTAL_W-1:0] total;
   } match_report_type;

   // One text byte waiting to be offered on the request channel.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } text_item_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   spm_req_if req_bus ();
   spm_rsp_if rsp_bus ();

   streaming_pattern_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Text bytes not yet offered, and results predicted but not yet seen.
   text_item_type    text_backlog [$];
   match_report_type pending_reports [$];

   int unsigned error_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned long_holds_requested = 0;
   int unsigned long_holds_served = 0;
   // When set, neither side inserts random idle gaps.
   bit          quiet_mode = 1'b0;
   // High for one cycle after the edge that accepted a request transaction.
   logic        req_fired = 1'b0;

   // The pattern as the stimulus generator sees it, used to build texts
   // that actually contain matches.
   logic [PATTERN_W-1:0] stim_main;
   logic [PATTERN_W-1:0] stim_alt;
   int unsigned          stim_length = 1;

   // Predictor copy of the registers and of the search state.
   logic [PATTERN_W-1:0] cfg_main;
   logic [PATTERN_W-1:0] cfg_alt;
   logic [LEN_W-1:0]     cfg_length;
   logic [WINDOW_W-1:0]  cfg_win_lo;
   logic [WINDOW_W-1:0]  cfg_win_hi;
   logic [BYTE_W-1:0]    seen_bytes [MAX_PATTERN];
   int unsigned          seen_count;
   logic [POS_W-1:0]     next_position;
   logic [TOTAL_W-1:0]   reported_matches;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle gap length: mostly none, sometimes short, rarely long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Start of a new text: history, fill count, position and counter go to zero.
   function automatic void clear_text();
      foreach (seen_bytes[i]) seen_bytes[i] = '0;
      seen_count = 0;
      next_position = '0;
      reported_matches = '0;
   endfunction

   // Advances the search by one text byte and queues the result it causes.
   // A match is checked against the newest pattern-length bytes, oldest byte
   // against pattern byte zero, and counts only when its start position lies
   // inside a non-empty window.
   function automatic void scan_text_byte(logic [BYTE_W-1:0] value, logic last);
      int unsigned       span;
      int                i;
      bit                hit;
      bit                aligned;
      logic [POS_W-1:0]  start_pos;
      logic [BYTE_W-1:0] seen;
      logic [BYTE_W-1:0] want_main;
      logic [BYTE_W-1:0] want_alt;
      match_report_type  report;
      span = (cfg_length > LEN_LIMIT) ? LEN_LIMIT : cfg_length;
      for (i = MAX_PATTERN - 1; i > 0; i--) seen_bytes[i] = seen_bytes[i-1];
      seen_bytes[0] = value;
      if (seen_count < MAX_PATTERN) seen_count++;
      hit = 1'b0;
      start_pos = '0;
      // A match needs span real bytes, so one cut short by a new text never counts.
      if (span > 0 && seen_count >= span) begin
         aligned = 1'b1;
         for (i = 0; i < span; i++) begin
            seen = seen_bytes[span-1-i];
            want_main = cfg_main[8*i +: 8];
            want_alt = cfg_alt[8*i +: 8];
            if (seen != want_main && seen != want_alt) aligned = 1'b0;
         end
         if (aligned) begin
            start_pos = next_position - POS_W'(span - 1);
            if (cfg_win_lo <= cfg_win_hi && start_pos >= cfg_win_lo &&
                start_pos <= cfg_win_hi) begin
               hit = 1'b1;
               if (reported_matches != '1) reported_matches++;
            end
         end
      end
      next_position++;
      if (hit || last) begin
         report.found = hit;
         report.start = hit ? start_pos[START_W-1:0] : '0;
         report.done = last;
         report.total = reported_matches;
         pending_reports = {pending_reports, report};
      end
      if (last) clear_text();
   endfunction

   task automatic report_failure(string msg);
      error_count++;
      if (error_count <= MAX_SHOWN) $display("%s", msg);
   endtask

   // Monitor and predictor. Every rising edge first checks an accepted result
   // transaction against the oldest prediction, then applies a register write
   // and finally feeds an accepted text byte to the predictor. A result can
   // never belong to a byte accepted at the same edge, so this order is safe.
   always @(posedge clock) begin : result_monitor
      match_report_type want;
      if (reset) begin
         cfg_main = '0;
         cfg_alt = '0;
         cfg_length = LEN_W'(1);
         cfg_win_lo = '0;
         cfg_win_hi = '1;
         clear_text();
         req_fired <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_reports.size() == 0) begin
               report_failure($sformatf(
                  "unexpected result: found=%0d start=%0d done=%0d total=%0d",
                  rsp_bus.match_found, rsp_bus.match_start, rsp_bus.stream_done,
                  rsp_bus.match_total));
            end else begin
               want = pending_reports.pop_front();
               if (rsp_bus.match_found !== want.found || rsp_bus.match_start !== want.start ||
                   rsp_bus.stream_done !== want.done || rsp_bus.match_total !== want.total)
               begin
                  report_failure($sformatf(
                     {"mismatch: expected found=%0d start=%0d done=%0d total=%0d,",
                      " got found=%0d start=%0d done=%0d total=%0d"},
                     want.found, want.start, want.done, want.total,
                     rsp_bus.match_found, rsp_bus.match_start, rsp_bus.stream_done,
                     rsp_bus.match_total));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_MAIN:   cfg_main = csr_data;
               CSR_PATTERN_ALT:    cfg_alt = csr_data;
               CSR_PATTERN_LENGTH: cfg_length = csr_data[LEN_W-1:0];
               CSR_WINDOW_START:   cfg_win_lo = csr_data[WINDOW_W-1:0];
               CSR_WINDOW_END:     cfg_win_hi = csr_data[WINDOW_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) scan_text_byte(req_bus.text_byte, req_bus.text_last);
         req_fired <= req_bus.valid && req_bus.ready;
      end
   end

   // Request driver. On each falling edge it holds an offered byte until it
   // has been taken; after a transaction it either idles for a random gap or
   // presents the next byte straight away, so valid never drops in between.
   always @(negedge clock) begin : text_driver
      text_item_type item;
      if (!req_bus.valid || req_fired) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (text_backlog.size() > 0) begin
            item = text_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.text_byte <= item.value;
            req_bus.text_last <= item.last;
            send_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result acceptor. Random stalls as on the request side, plus the long
   // hold-off when the stimulus asks for one; the hold is counted here.
   always @(negedge clock) begin : result_acceptor
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (long_holds_served != long_holds_requested) begin
         long_holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   function automatic void push_item(logic [BYTE_W-1:0] value, logic last);
      text_item_type item;
      item.value = value;
      item.last = last;
      text_backlog = {text_backlog, item};
   endfunction

   // One pattern byte, taken from either table at random.
   function automatic logic [BYTE_W-1:0] pattern_byte(int unsigned k);
      logic [PATTERN_W-1:0] src;
      src = $urandom_range(0, 1) ? stim_alt : stim_main;
      return src[8*k +: 8];
   endfunction

   // Waits until no byte is left to send and every predicted result has been
   // seen, then lets the pipeline drain bytes that produce no result.
   // Sampling one step after the edge keeps this clear of the edge itself.
   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (text_backlog.size() != 0 || req_bus.valid || pending_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(spm_csr_index_type index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes every register once the block is idle. Upper data bits of the
   // narrow registers carry noise, which the block must ignore.
   task automatic configure(logic [PATTERN_W-1:0] main, logic [PATTERN_W-1:0] alt,
                            int unsigned length, logic [WINDOW_W-1:0] lo,
                            logic [WINDOW_W-1:0] hi, bit quiet);
      logic [CSR_DATA_W-1:0] noise;
      noise = {$urandom, $urandom};
      wait_idle();
      write_register(CSR_PATTERN_MAIN, main);
      write_register(CSR_PATTERN_ALT, alt);
      write_register(CSR_PATTERN_LENGTH, {noise[CSR_DATA_W-1:LEN_W], LEN_W'(length)});
      write_register(CSR_WINDOW_START, {noise[CSR_DATA_W-1:WINDOW_W], lo});
      write_register(CSR_WINDOW_END, {noise[WINDOW_W-1:0], hi});
      stim_main = main;
      stim_alt = alt;
      stim_length = (length == 0) ? 1 : ((length > LEN_LIMIT) ? LEN_LIMIT : length);
      // Stimulus changes are made on a rising edge, away from the drivers.
      @(posedge clock);
      quiet_mode = quiet;
   endtask

   // Random texts of mostly short length. Most content is whole pattern
   // copies with a random choice of table per byte, or loose pattern bytes,
   // so overlapping matches are common; some copies carry one corrupt byte,
   // some bytes are plain noise, and the final truncation leaves matches
   // cut short by the end of the text.
   task automatic push_random_texts(int unsigned count);
      logic [BYTE_W-1:0] text [$];
      int unsigned       produced;
      int unsigned       tlen;
      int unsigned       r;
      int unsigned       k;
      int unsigned       spot;
      produced = 0;
      while (produced < count) begin
         text.delete();
         tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
         while (text.size() < tlen) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               spot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, stim_length - 1)
                                                   : stim_length;
               for (k = 0; k < stim_length; k++)
                  text = {text, ((k == spot) ? BYTE_W'($urandom) : pattern_byte(k))};
            end else if (r < 85) begin
               text = {text, pattern_byte($urandom_range(0, stim_length - 1))};
            end else begin
               text = {text, BYTE_W'($urandom_range(0, 255))};
            end
         end
         for (k = 0; k < tlen; k++) push_item(text[k], k == tlen - 1);
         produced += tlen;
      end
   endtask

   initial begin
      logic [PATTERN_W-1:0] main;
      logic [PATTERN_W-1:0] alt;
      logic [BYTE_W-1:0]    letter;
      logic [WINDOW_W-1:0]  lo;
      logic [WINDOW_W-1:0]  hi;
      int unsigned          length;
      int unsigned          mode;
      int unsigned          wmode;
      int                   phase;
      int                   k;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = '0;
      req_bus.text_last = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_PATTERN_MAIN;
      csr_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults after reset: a one-byte pattern of zero and a
      // window over every position. Both byte extremes and both values of
      // the last flag appear.
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b1);

      // Case-insensitive "abc": two overlapping-free matches, then a match
      // cut short by the end of the text.
      configure(64'h0000_0000_0063_6261, 64'h0000_0000_0043_4241, 3, '0, '1, 1'b0);
      push_item(8'h61, 1'b0);
      push_item(8'h42, 1'b0);
      push_item(8'h63, 1'b0);
      push_item(8'h41, 1'b0);
      push_item(8'h62, 1'b0);
      push_item(8'h43, 1'b0);
      push_item(8'h61, 1'b0);
      push_item(8'h62, 1'b1);

      // Pattern length zero never matches, even on a byte equal to the pattern.
      configure(64'h78, 64'h78, 0, '0, '1, 1'b0);
      push_item(8'h78, 1'b0);
      push_item(8'h79, 1'b1);

      // An oversized length saturates to eight bytes; the match completes on
      // the final byte, so found and done arrive together.
      configure('1, '1, 15, '0, '1, 1'b1);
      for (k = 0; k < 8; k++) push_item(8'hFF, k == 7);

      // An empty window reports nothing.
      configure(64'h41, 64'h41, 1, 32'd5, 32'd4, 1'b0);
      push_item(8'h41, 1'b0);
      push_item(8'h41, 1'b1);

      // A narrow window cuts off matches on both sides of it.
      configure(64'h41, 64'h61, 1, 32'd1, 32'd2, 1'b0);
      push_item(8'h41, 1'b0);
      push_item(8'h61, 1'b0);
      push_item(8'h41, 1'b0);
      push_item(8'h61, 1'b1);

      // Random phases. The first four force each pattern flavor once, and the
      // window flavors include fully random bounds and the top position.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 5) begin
            // Every byte is a match, so every byte yields a result. While the
            // receiver holds off, the sender keeps offering without gaps and
            // the block must fill up and stall its request channel.
            configure(64'h61, 64'h41, 1, '0, '1, 1'b1);
            for (k = 0; k < 60; k++) push_item($urandom_range(0, 1) ? 8'h61 : 8'h41, k == 59);
            long_holds_requested++;
         end

         mode = (phase < 4) ? phase : $urandom_range(0, 3);
         for (k = 0; k < 8; k++) begin
            case (mode)
               0: begin
                  letter = 8'h61 + BYTE_W'($urandom_range(0, 3));
                  main[8*k +: 8] = letter;
                  alt[8*k +: 8] = letter - 8'h20;
               end
               1: begin
                  main[8*k +: 8] = BYTE_W'($urandom);
                  alt[8*k +: 8] = BYTE_W'($urandom);
               end
               2: begin
                  letter = 8'h30 + BYTE_W'($urandom_range(0, 2));
                  main[8*k +: 8] = letter;
                  alt[8*k +: 8] = letter;
               end
               default: begin
                  main[8*k +: 8] = EDGE_BYTES[$urandom_range(0, 3)];
                  alt[8*k +: 8] = EDGE_BYTES[$urandom_range(0, 3)];
               end
            endcase
         end

         case ($urandom_range(0, 19))
            0:       length = 0;
            1:       length = $urandom_range(9, 15);
            default: length = $urandom_range(1, 8);
         endcase
         if (phase == 1) length = 8;
         if (phase == 2) length = 1;

         wmode = (phase == 3) ? 9 : ((phase == 4) ? 6 : $urandom_range(0, 9));
         case (wmode)
            6: begin
               lo = $urandom_range(0, 20);
               hi = lo + $urandom_range(0, 30);
            end
            7: begin
               lo = $urandom_range(5, 30);
               hi = lo - $urandom_range(1, 5);
            end
            8: begin
               lo = '1;
               hi = '1;
            end
            9: begin
               lo = $urandom;
               hi = $urandom;
            end
            default: begin
               lo = '0;
               hi = '1;
            end
         endcase

         configure(main, alt, length, lo, hi, phase % 4 == 3);
         push_random_texts(PHASE_ITEMS);
      end

      wait_idle();
      if (error_count == 0) begin
         $display("streaming_pattern_matcher_tb: done, clean");
      end else begin
         $display("streaming_pattern_matcher_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("streaming_pattern_matcher_tb: done, errors");
      $finish;
   end

endmodule
